[rtl/phc_pkg.sv]
// phc_pkg: types and constants for the pipeline hazard cycle counter
// no dependencies; used by every module of the block
`default_nettype none

package phc_pkg;

  localparam logic [2:0] FMT_R  = 3'd0;
  localparam logic [2:0] FMT_I  = 3'd1;
  localparam logic [2:0] FMT_CB = 3'd4;

  localparam logic [4:0]  ZERO_REG       = 5'd31;
  localparam logic [2:0]  BRANCH_PENALTY = 3'd3;
  localparam logic [31:0] FILL_CYCLES    = 32'd4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0] format_class;
    logic       is_load;
    logic [4:0] dest_reg;
    logic [4:0] src_reg_n;
    logic [4:0] src_reg_m;
  } item_t;

  typedef struct packed {
    logic [31:0] unpipelined_cycles;
    logic [31:0] pipelined_cycles;
    logic [31:0] bypass_cycles;
    logic [31:0] data_hazard_count;
    logic [31:0] control_hazard_count;
  } result_t;

  // per-instruction counter increments, worked out by the front end
  typedef struct packed {
    logic [2:0] stall_inc;
    logic [2:0] fwd_inc;
    logic [1:0] hazard_inc;
    logic       branch;
  } incr_t;

endpackage

`default_nettype wire

[rtl/phc_front.sv]
// phc_front: accepts instructions, keeps the EX/MEM history, computes increments
// depends on phc_pkg
`default_nettype none

module phc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire phc_pkg::item_t item,
  input  wire logic           q_full,
  output logic                q_push,
  output phc_pkg::incr_t      q_data
);
  import phc_pkg::*;

  logic       ex_writes, ex_load, mem_writes;
  logic [4:0] ex_dest, mem_dest;
  logic       ex_hit, mem_hit, is_cb, new_writes;

  assign item_ready = !q_full;
  assign q_push     = item_valid && item_ready;

  always_comb begin
    ex_hit  = ex_writes && (ex_dest != ZERO_REG) &&
              ((ex_dest == item.src_reg_n) || (ex_dest == item.src_reg_m));
    mem_hit = mem_writes && (mem_dest != ZERO_REG) &&
              ((mem_dest == item.src_reg_n) || (mem_dest == item.src_reg_m));
    is_cb   = (item.format_class == FMT_CB);
    new_writes = (item.format_class == FMT_R) || (item.format_class == FMT_I) ||
                 item.is_load;
    // ex hit costs two stalls, mem hit one; a load in ex costs one with forwarding
    q_data.stall_inc  = {1'b0, ex_hit, 1'b0} + {2'b0, mem_hit} +
                        (is_cb ? BRANCH_PENALTY : 3'd0) + 3'd1;
    q_data.fwd_inc    = {2'b0, ex_hit && ex_load} +
                        (is_cb ? BRANCH_PENALTY : 3'd0) + 3'd1;
    q_data.hazard_inc = {1'b0, ex_hit} + {1'b0, mem_hit};
    q_data.branch     = is_cb;
  end

  // mem_load is never needed: a load in mem adds nothing to the forwarded count
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_writes  <= 1'b0;
      ex_load    <= 1'b0;
      ex_dest    <= '0;
      mem_writes <= 1'b0;
      mem_dest   <= '0;
    end else if (q_push) begin
      mem_writes <= ex_writes;
      mem_dest   <= ex_dest;
      ex_writes  <= new_writes;
      ex_load    <= item.is_load;
      ex_dest    <= item.dest_reg;
    end
  end

endmodule

`default_nettype wire

[rtl/phc_queue.sv]
// phc_queue: short queue of increment records between front and back ends
// depends on phc_pkg
`default_nettype none

module phc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire phc_pkg::incr_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output phc_pkg::incr_t      pop_data
);
  import phc_pkg::*;

  incr_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

[rtl/phc_back.sv]
// phc_back: applies queued increments to the five counters, holds the result
// depends on phc_pkg
`default_nettype none

module phc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_not_empty,
  input  wire phc_pkg::incr_t q_data,
  output logic                q_pop,
  output logic                result_valid,
  input  wire logic           result_ready,
  output phc_pkg::result_t    result
);
  import phc_pkg::*;

  logic [31:0] plain_count, stall_count, forward_count, data_hazards, branch_hazards;

  // counters only move on a pop, so they double as the output register
  assign q_pop = q_not_empty && (!result_valid || result_ready);

  assign result.unpipelined_cycles   = plain_count;
  assign result.pipelined_cycles     = stall_count;
  assign result.bypass_cycles        = forward_count;
  assign result.data_hazard_count    = data_hazards;
  assign result.control_hazard_count = branch_hazards;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid   <= 1'b0;
      plain_count    <= '0;
      stall_count    <= FILL_CYCLES;
      forward_count  <= FILL_CYCLES;
      data_hazards   <= '0;
      branch_hazards <= '0;
    end else begin
      if (q_pop) begin
        result_valid   <= 1'b1;
        plain_count    <= plain_count + 32'd1;
        stall_count    <= stall_count + {29'b0, q_data.stall_inc};
        forward_count  <= forward_count + {29'b0, q_data.fwd_inc};
        data_hazards   <= data_hazards + {30'b0, q_data.hazard_inc};
        branch_hazards <= branch_hazards + {31'b0, q_data.branch};
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_gives_result: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> result_valid)
    else $error("pop did not produce a result");
  a_plain_steps: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (plain_count == $past(plain_count) + 32'd1))
    else $error("instruction count did not advance by one");
  a_hold_no_pop: assert property (@(posedge clk) disable iff (rst)
    !q_pop |=> $stable(stall_count) && $stable(forward_count))
    else $error("cycle counters moved without a pop");
`endif

endmodule

`default_nettype wire

[rtl/pipeline_hazard_cycle_counter.sv]
// pipeline_hazard_cycle_counter: top level, front end + queue + counter back end
// depends on phc_pkg, phc_front, phc_queue, phc_back
//
//   channel | signals                            | payload
//   --------+------------------------------------+------------------
//   request | item_valid / item_ready / item     | phc_pkg::item_t
//   result  | result_valid / result_ready/result | phc_pkg::result_t
//
// one instruction per cycle sustained unless the queue is full; when the queue is empty,
// an accepted instruction passes the queue write and then the counter register
// the 2-entry queue lets the front keep accepting while a result waits
// synchronous reset clears history and queue, sets counters to start values; no clearing pass
`default_nettype none

module pipeline_hazard_cycle_counter (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire phc_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output phc_pkg::result_t      result
);
  import phc_pkg::*;

  logic  q_push, q_full, q_pop, q_not_empty;
  incr_t push_data, pop_data;

  phc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (push_data)
  );

  phc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  phc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_data       (pop_data),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
